[rtl/vmnl_pkg.sv]
`default_nettype none

package vmnl_pkg;

  // Default grid size and search limit
  localparam int GridXDef     = 32;
  localparam int GridYDef     = 32;
  localparam int GridZDef     = 32;
  localparam int MaxRadiusDef = 8;

  // Field widths of one request
  localparam int OpW     = 2;
  localparam int PosW    = 5;
  localparam int DensW   = 16;
  localparam int MatW    = 8;
  localparam int RadInW  = 4;

  // Opcodes
  localparam logic [OpW-1:0] OP_RECORD = 2'd0;
  localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpW-1:0] OP_QUERY  = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/vmnl_ram.sv]
`default_nettype none

module vmnl_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 32768
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/voxel_material_nearest_lookup_top.sv]
// Voxel material lookup over a dense GRID_X x GRID_Y x GRID_Z grid. Each cell
// holds a valid mark and an 8-bit material tag in one synchronous RAM, addressed
// by the concatenated z, y, x coordinates. After reset the block sweeps the RAM
// once, one entry per cycle, and takes no request until done. Record and remove
// requests are written without leaving the idle state and return nothing. A
// query probes its own cell, then each Chebyshev shell of radius 1 up to the
// saturated search radius, z outermost and x innermost, one probe per cycle,
// reading the RAM only for cells inside the grid; it answers with the first
// tagged cell on found/tuser. No other request is taken until the answer goes
// to the output register; the single RAM read port sets the probe rate. A
// finished answer waits in the output register, and record or remove requests
// are still taken meanwhile.
`default_nettype none

module voxel_material_nearest_lookup_top
  import vmnl_pkg::*;
#(
  parameter int GRID_X     = GridXDef,
  parameter int GRID_Y     = GridYDef,
  parameter int GRID_Z     = GridZDef,
  parameter int MAX_RADIUS = MaxRadiusDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // pos_x[4:0], pos_y[9:5], pos_z[14:10], old_density[30:15],
  // new_density[46:31], material_in[54:47], search_radius[58:55], zero[63:59]
  input  wire logic [63:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // material_out[7:0]
  output      logic [7:0]  m_axis_tdata,
  // found[0]
  output      logic        m_axis_tuser
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int AW    = XW + YW + ZW;
  localparam int DEPTH = 1 << AW;
  localparam int GM0   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
  localparam int GM1   = (GM0 > GRID_Z) ? GM0 : GRID_Z;
  localparam int GMAX  = (GM1 > 32) ? GM1 : 32;
  localparam int RW    = $clog2(MAX_RADIUS + 1) + 1;
  localparam int CW    = $clog2(GMAX + MAX_RADIUS + 1) + 2;
  localparam int DW    = MatW + 1;

  localparam logic signed [CW-1:0] GxS = CW'(GRID_X);
  localparam logic signed [CW-1:0] GyS = CW'(GRID_Y);
  localparam logic signed [CW-1:0] GzS = CW'(GRID_Z);

  // Request fields
  logic        [PosW-1:0]   in_x, in_y, in_z;
  logic signed [DensW-1:0]  in_old, in_new;
  logic        [MatW-1:0]   in_mat;
  logic        [RadInW-1:0] in_rad;
  logic signed [CW-1:0]     in_cx, in_cy, in_cz;
  logic                     in_grid;

  assign in_x   = s_axis_tdata[4:0];
  assign in_y   = s_axis_tdata[9:5];
  assign in_z   = s_axis_tdata[14:10];
  assign in_old = s_axis_tdata[30:15];
  assign in_new = s_axis_tdata[46:31];
  assign in_mat = s_axis_tdata[54:47];
  assign in_rad = s_axis_tdata[58:55];

  assign in_cx = {{(CW-PosW){1'b0}}, in_x};
  assign in_cy = {{(CW-PosW){1'b0}}, in_y};
  assign in_cz = {{(CW-PosW){1'b0}}, in_z};

  function automatic logic in_range(input logic signed [CW-1:0] c,
                                    input logic signed [CW-1:0] lim);
    in_range = !c[CW-1] && (c < lim);
  endfunction

  assign in_grid = in_range(in_cx, GxS) && in_range(in_cy, GyS) && in_range(in_cz, GzS);

  // State
  state_e               state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic signed [RW-1:0] r_q, r_d, rad_q, rad_d;
  logic signed [RW-1:0] dx_q, dx_d, dy_q, dy_d, dz_q, dz_d;
  logic signed [CW-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic                 rd_pend_q, rd_pend_d, rd_in_q, rd_in_d;
  logic                 res_found_q, res_found_d;
  logic [MatW-1:0]      res_mat_q, res_mat_d;
  logic                 m_valid_q, m_valid_d, m_found_q, m_found_d;
  logic [MatW-1:0]      m_mat_q, m_mat_d;

  // RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // Scan cell
  logic signed [CW-1:0] cx, cy, cz;
  logic                 cell_in, cell_last, row_edge, hit, accept, out_free;

  assign cx = px_q + {{(CW-RW){dx_q[RW-1]}}, dx_q};
  assign cy = py_q + {{(CW-RW){dy_q[RW-1]}}, dy_q};
  assign cz = pz_q + {{(CW-RW){dz_q[RW-1]}}, dz_q};
  assign cell_in   = in_range(cx, GxS) && in_range(cy, GyS) && in_range(cz, GzS);
  assign cell_last = (r_q == rad_q) && (dz_q == r_q) && (dy_q == r_q) && (dx_q == r_q);
  assign row_edge  = (dy_q == r_q) || (dy_q == -r_q) || (dz_q == r_q) || (dz_q == -r_q);
  assign hit       = rd_pend_q && rd_in_q && ram_rdata[MatW];
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign out_free  = !m_valid_q || m_axis_tready;
  assign ram_raddr = {cz[ZW-1:0], cy[YW-1:0], cx[XW-1:0]};

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_mat_q;
  assign m_axis_tuser  = m_found_q;

  // Next state, RAM control and result handling
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    r_d         = r_q;
    rad_d       = rad_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    dz_d        = dz_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    rd_pend_d   = 1'b0;
    rd_in_d     = rd_in_q;
    res_found_d = res_found_q;
    res_mat_d   = res_mat_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_found_d   = m_found_q;
    m_mat_d     = m_mat_q;
    ram_we      = 1'b0;
    ram_waddr   = {in_cz[ZW-1:0], in_cy[YW-1:0], in_cx[XW-1:0]};
    ram_wdata   = '0;
    ram_re      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the RAM, clearing every valid mark
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            OP_RECORD: begin
              ram_we    = (in_old > 0) && (in_new < in_old) && in_grid;
              ram_wdata = {1'b1, in_mat};
            end
            OP_REMOVE: begin
              ram_we    = (in_old <= 0) && (in_new > 0) && in_grid;
              ram_wdata = '0;
            end
            OP_QUERY: begin
              px_d    = in_cx;
              py_d    = in_cy;
              pz_d    = in_cz;
              r_d     = '0;
              dx_d    = '0;
              dy_d    = '0;
              dz_d    = '0;
              rad_d   = (int'(in_rad) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(in_rad);
              state_d = ST_SCAN;
            end
            default: begin
              // Unused opcode: drop
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one probe per cycle and check the one issued last cycle
        ram_re    = cell_in;
        rd_pend_d = 1'b1;
        rd_in_d   = cell_in;
        if (hit) begin
          res_found_d = 1'b1;
          res_mat_d   = ram_rdata[MatW-1:0];
          state_d     = ST_OUT;
        end else if (cell_last) begin
          state_d = ST_WAIT;
        end else if (dx_q != r_q) begin
          dx_d = row_edge ? dx_q + RW'(1) : r_q;
        end else if (dy_q != r_q) begin
          dy_d = dy_q + RW'(1);
          dx_d = -r_q;
        end else if (dz_q != r_q) begin
          dz_d = dz_q + RW'(1);
          dy_d = -r_q;
          dx_d = -r_q;
        end else begin
          r_d  = r_q + RW'(1);
          dz_d = -(r_q + RW'(1));
          dy_d = -(r_q + RW'(1));
          dx_d = -(r_q + RW'(1));
        end
      end

      ST_WAIT: begin
        // Check the final probe
        res_found_d = hit;
        res_mat_d   = hit ? ram_rdata[MatW-1:0] : '0;
        state_d     = ST_OUT;
      end

      ST_OUT: begin
        // Hand the answer to the output register once it is free
        if (out_free) begin
          m_valid_d = 1'b1;
          m_found_d = res_found_q;
          m_mat_d   = res_mat_q;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      rd_pend_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      rd_pend_q <= rd_pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    r_q         <= r_d;
    rad_q       <= rad_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    dz_q        <= dz_d;
    px_q        <= px_d;
    py_q        <= py_d;
    pz_q        <= pz_d;
    rd_in_q     <= rd_in_d;
    res_found_q <= res_found_d;
    res_mat_q   <= res_mat_d;
    m_found_q   <= m_found_d;
    m_mat_q     <= m_mat_d;
  end

  // Tag store: valid mark over material
  vmnl_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
